// ----- design/oai_pkg.sv -----
// oai_pkg: shared widths, operation and status codes, and the command and
// status structs between the controller and the datapath of the ordered array.
// No dependencies.
`default_nettype none

package oai_pkg;

  // Fixed field widths of the beats
  localparam int OP_W     = 2;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Parameter defaults
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch a new beat and set up the shift
    logic step;    // shift step: issue a read and/or write back
    logic place;   // write the new word at its position
    logic commit;  // update the count and load the result register
  } oai_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_err;     // incoming beat fails its range or full check
    logic shift_last;  // no reads left to issue in the shift
    logic ins_op;      // latched operation is insert or append
  } oai_sts_t;

endpackage

`default_nettype wire

// ----- design/ordered_array_insert_remove_core.sv -----
// ordered_array_insert_remove_core: top level of the ordered array with
// insert, append, remove and read. Instantiates oai_ctrl and oai_datapath.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_op, in_position, in_value
//   out_     output     out_valid / out_stall out_status, out_read_value, out_count
//
// One beat at a time. The shift moves one entry a cycle through the entry
// memory (one write port, one read port).
// Reset clears the count and the control state; the memory is not cleared.
// The next beat is taken while a result waits in the output register; a
// stalled result holds its payload.
`default_nettype none

module ordered_array_insert_remove_core
  import oai_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire  logic                       clk,
  input  wire  logic                       rst_n,
  input  wire  logic                       in_valid,
  output       logic                       in_stall,
  input  wire  logic        [OP_W-1:0]     in_op,
  input  wire  logic        [POS_W-1:0]    in_position,
  input  wire  logic signed [VAL_W-1:0]    in_value,
  output       logic                       out_valid,
  input  wire  logic                       out_stall,
  output       logic        [STATUS_W-1:0] out_status,
  output       logic signed [VAL_W-1:0]    out_read_value,
  output       logic        [COUNT_W-1:0]  out_count
);

  oai_cmd_t cmd;
  oai_sts_t sts;

  // Sequencer
  oai_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and result path
  oai_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

endmodule

`default_nettype wire

// ----- design/oai_datapath.sv -----
// oai_datapath: entry memory, count register, shift pointers and result
// register of the ordered array. Driven by oai_ctrl; depends on oai_pkg.
`default_nettype none

module oai_datapath
  import oai_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire  logic                       clk,
  input  wire  logic                       rst_n,
  input  wire  oai_cmd_t                   cmd,
  output       oai_sts_t                   sts,
  input  wire  logic        [OP_W-1:0]     in_op,
  input  wire  logic        [POS_W-1:0]    in_position,
  input  wire  logic signed [VAL_W-1:0]    in_value,
  output       logic        [STATUS_W-1:0] out_status,
  output       logic signed [VAL_W-1:0]    out_read_value,
  output       logic        [COUNT_W-1:0]  out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int RW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

  // Storage
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_r;

  // Control registers
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;

  // Latched beat
  logic [OP_W-1:0]       op_r;
  logic [AW-1:0]         pos_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [STATUS_W-1:0]   stat_r;
  logic                  dir_up_r;
  logic                  wb_r;

  // Decode of the incoming beat
  logic [PW-1:0]       cnt_ext, pos_eff;
  logic                is_ins;
  logic [STATUS_W-1:0] req_status;
  logic [CW-1:0]       pos_c, cnt_m1, moves;
  logic [AW-1:0]       ptr_init;
  logic [RW-1:0]       val_ext;

  always_comb begin
    cnt_ext = PW'(count_r);
    pos_eff = (in_op == OP_APPEND) ? cnt_ext : PW'(in_position);
    is_ins  = (in_op == OP_INSERT) || (in_op == OP_APPEND);
    if (is_ins) begin
      if (pos_eff > cnt_ext)                   req_status = ST_RANGE;
      else if (count_r == CW'(CAPACITY))       req_status = ST_FULL;
      else                                     req_status = ST_OK;
    end else begin
      if (pos_eff >= cnt_ext)                  req_status = ST_RANGE;
      else                                     req_status = ST_OK;
    end
    pos_c  = pos_eff[CW-1:0];
    cnt_m1 = count_r - CW'(1);
    unique case (in_op)
      OP_INSERT, OP_APPEND: begin
        moves    = count_r - pos_c;
        ptr_init = cnt_m1[AW-1:0];
      end
      OP_REMOVE: begin
        moves    = cnt_m1 - pos_c;
        ptr_init = pos_c[AW-1:0] + AW'(1);
      end
      default: begin
        moves    = CW'(1);
        ptr_init = pos_c[AW-1:0];
      end
    endcase
    val_ext = RW'($unsigned(in_value));
  end

  assign sts.req_err    = (req_status != ST_OK);
  assign sts.shift_last = (n_r == '0);
  assign sts.ins_op     = dir_up_r;

  // Shift sequencing: reads run one ahead of the write-backs
  logic                  rd_en, wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  always_comb begin
    n_nxt         = n_r;
    pend_nxt      = pend_r;
    ptr_nxt       = ptr_r;
    pend_addr_nxt = pend_addr_r;
    rd_en         = 1'b0;
    if (cmd.start) begin
      n_nxt    = (req_status == ST_OK) ? moves : '0;
      pend_nxt = 1'b0;
      ptr_nxt  = ptr_init;
    end else if (cmd.step) begin
      if (n_r != '0) begin
        rd_en         = 1'b1;
        n_nxt         = n_r - CW'(1);
        pend_nxt      = 1'b1;
        pend_addr_nxt = dir_up_r ? (ptr_r + AW'(1)) : (ptr_r - AW'(1));
        ptr_nxt       = dir_up_r ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
      end else begin
        pend_nxt = 1'b0;
      end
    end
    // write port: shifted word or the placed word
    wr_en   = 1'b0;
    wr_addr = pend_addr_r;
    wr_data = rdata_r;
    if (cmd.step && pend_r && wb_r) begin
      wr_en = 1'b1;
    end else if (cmd.place) begin
      wr_en   = 1'b1;
      wr_addr = pos_r;
      wr_data = word_r;
    end
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[ptr_r];
    end
  end

  // Count update on commit
  always_comb begin
    count_nxt = count_r;
    if (cmd.commit && (stat_r == ST_OK)) begin
      unique case (op_r)
        OP_INSERT, OP_APPEND: count_nxt = count_r + CW'(1);
        OP_REMOVE:            count_nxt = count_r - CW'(1);
        default:              count_nxt = count_r;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      n_r     <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      n_r     <= n_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Beat and pointer registers
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    pend_addr_r <= pend_addr_nxt;
    if (cmd.start) begin
      op_r     <= in_op;
      pos_r    <= pos_c[AW-1:0];
      word_r   <= val_ext[DATA_WIDTH-1:0];
      stat_r   <= req_status;
      dir_up_r <= is_ins;
      wb_r     <= (in_op != OP_READ);
    end
  end

  // Result register
  logic [EW-1:0] cnt_out_ext;
  logic [RW-1:0] rd_ext;
  assign cnt_out_ext = EW'(count_nxt);
  assign rd_ext      = RW'(rdata_r);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status     <= stat_r;
      out_read_value <= ((op_r == OP_READ) && (stat_r == ST_OK)) ?
                        rd_ext[VAL_W-1:0] : '0;
      out_count      <= cnt_out_ext[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/oai_ctrl.sv -----
// oai_ctrl: sequencing state machine and result valid flag of the ordered
// array. Commands oai_datapath; depends on oai_pkg.
`default_nettype none

module oai_ctrl
  import oai_pkg::*;
(
  input  wire  logic     clk,
  input  wire  logic     rst_n,
  input  wire  logic     in_valid,
  output       logic     in_stall,
  output       logic     out_valid,
  input  wire  logic     out_stall,
  input  wire  oai_sts_t sts,
  output       oai_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, load;

  // Handshake and commands
  assign in_stall    = (state_r != S_IDLE);
  assign accept      = (state_r == S_IDLE) && in_valid;
  assign load        = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign cmd.start   = accept;
  assign cmd.step    = (state_r == S_SHIFT);
  assign cmd.place   = (state_r == S_PLACE);
  assign cmd.commit  = load;
  assign out_valid   = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = sts.req_err ? S_DONE : S_SHIFT;
      S_SHIFT: if (sts.shift_last) state_nxt = sts.ins_op ? S_PLACE : S_DONE;
      S_PLACE: state_nxt = S_DONE;
      S_DONE:  if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // result slot: filled on load, emptied when taken
    if (load)            out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sim/oai_array_checker.sv -----
// oai_array_checker: watches both channels of the ordered array core, keeps its
// own copy of the stored words, predicts each result beat and compares it.
// Depends on oai_pkg for widths and for the operation and status codes.

module oai_array_checker
  import oai_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic        [OP_W-1:0]     in_op,
  input  wire logic        [POS_W-1:0]    in_position,
  input  wire logic signed [VAL_W-1:0]    in_value,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic        [STATUS_W-1:0] out_status,
  input  wire logic signed [VAL_W-1:0]    out_read_value,
  input  wire logic        [COUNT_W-1:0]  out_count,
  output int                              failures,
  output int                              pending,
  output int                              stored_count
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    read_value;
    logic [COUNT_W-1:0]  count;
  } array_result_t;

  // Shadow of the array contents and fill level
  logic [VAL_W-1:0] words [CAPACITY];
  int               n_words = 0;
  int               mismatches = 0;
  array_result_t    result_q [$];

  // Apply one beat to the shadow array and return the result it must give
  function automatic array_result_t apply_beat(logic [OP_W-1:0] op,
                                               logic [POS_W-1:0] position,
                                               logic [VAL_W-1:0] value);
    array_result_t res;
    int            idx;
    int            i;
    res = '0;
    res.status = ST_OK;
    idx = (op == OP_APPEND) ? n_words : int'(position);
    case (op)
      OP_INSERT, OP_APPEND: begin
        // range check comes before the full check
        if (idx > n_words) begin
          res.status = ST_RANGE;
        end else if (n_words >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = n_words; i > idx; i--) words[i] = words[i-1];
          words[idx] = value;
          n_words++;
        end
      end
      OP_REMOVE: begin
        if (idx >= n_words) begin
          res.status = ST_RANGE;
        end else begin
          for (i = idx; i + 1 < n_words; i++) words[i] = words[i+1];
          n_words--;
        end
      end
      default: begin
        if (idx >= n_words) res.status = ST_RANGE;
        else res.read_value = words[idx];
      end
    endcase
    res.count = COUNT_W'(n_words);
    return res;
  endfunction

  // Result beats are matched before the input beat of the same edge is queued
  always @(posedge clk) begin
    array_result_t want;
    if (!rst_n) begin
      n_words = 0;
      result_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: status %0d read_value %0d count %0d",
                   $time, out_status, out_read_value, out_count);
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_status);
          end
          if (out_read_value !== want.read_value) begin
            mismatches++;
            $display("%0t: read_value expected %0d actual %0d",
                     $time, $signed(want.read_value), out_read_value);
          end
          if (out_count !== want.count) begin
            mismatches++;
            $display("%0t: count expected %0d actual %0d",
                     $time, want.count, out_count);
          end
        end
      end
      if (in_valid && !in_stall) begin
        result_q.push_back(apply_beat(in_op, in_position, in_value));
      end
    end
    pending      = result_q.size();
    stored_count = n_words;
    failures     = mismatches + result_q.size();
  end

endmodule

// ----- sim/ordered_array_insert_remove_core_test.sv -----
// ordered_array_insert_remove_core_test: drives insert, append, remove and read
// beats into the ordered array core under several idling mixes and gives the verdict.
// Depends on oai_pkg, ordered_array_insert_remove_core and oai_array_checker.

module ordered_array_insert_remove_core_test;
  import oai_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int RANDOM_BEATS = 80;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 100;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic        [OP_W-1:0]     in_op = OP_READ;
  logic        [POS_W-1:0]    in_position = '0;
  logic signed [VAL_W-1:0]    in_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic        [STATUS_W-1:0] out_status;
  logic signed [VAL_W-1:0]    out_read_value;
  logic        [COUNT_W-1:0]  out_count;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int failures;
  int pending;
  int stored_count;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ordered_array_insert_remove_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_position(in_position),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_read_value(out_read_value),
    .out_count(out_count)
  );

  oai_array_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_position(in_position),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_read_value(out_read_value),
    .out_count(out_count),
    .failures(failures),
    .pending(pending),
    .stored_count(stored_count)
  );

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ordered_array_insert_remove_core_test: FAIL");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [POS_W-1:0] position,
                           input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_position <= position;
    in_value    <= value;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // Random beat, leaning towards filling or emptying the array
  task automatic send_random(input bit grow);
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (grow) begin
      op = (pick < 35) ? OP_INSERT : (pick < 65) ? OP_APPEND :
           (pick < 80) ? OP_REMOVE : OP_READ;
    end else begin
      op = (pick < 15) ? OP_INSERT : (pick < 25) ? OP_APPEND :
           (pick < 75) ? OP_REMOVE : OP_READ;
    end
    // mostly in range, some at the boundary, some anywhere in the field
    pick = $urandom_range(99);
    if (pick < 8) begin
      position = POS_W'($urandom_range(127));
    end else if (pick < 18) begin
      position = POS_W'(stored_count + $urandom_range(1));
    end else if (op == OP_INSERT || stored_count == 0) begin
      position = POS_W'($urandom_range(stored_count));
    end else begin
      position = POS_W'($urandom_range(stored_count - 1));
    end
    pick = $urandom_range(9);
    case (pick)
      0:       value = 32'h8000_0000;
      1:       value = 32'h7fff_ffff;
      2:       value = '0;
      3:       value = '1;
      default: value = $urandom;
    endcase
    send_beat(op, position, value);
  endtask

  initial begin
    int phase;
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (phase = 0; phase < 4; phase++) begin
      // hold off until the core has drained, then change the idling mix
      in_valid <= 1'b0;
      do @(negedge clk); while (pending != 0);
      @(posedge clk);
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      @(negedge clk);

      if (phase == 0) begin
        // empty array: every position is out of range
        send_beat(OP_READ, 0, 32'h1111_1111);
        send_beat(OP_REMOVE, 0, 0);
        send_beat(OP_INSERT, 1, 32'h2222_2222);
        send_beat(OP_INSERT, 127, 32'h3333_3333);
        // build up with extreme words; append ignores its position
        send_beat(OP_APPEND, 0, 32'h7fff_ffff);
        send_beat(OP_INSERT, 0, 32'h8000_0000);
        send_beat(OP_INSERT, 2, 32'hffff_ffff);
        send_beat(OP_INSERT, 1, 32'h0000_0000);
        send_beat(OP_APPEND, 127, 32'h1234_5678);
        for (n = 0; n < 5; n++) send_beat(OP_READ, POS_W'(n), 32'hffff_ffff);
        send_beat(OP_READ, 127, 0);
        send_beat(OP_REMOVE, 127, 0);
        send_beat(OP_INSERT, 6, 32'h5555_5555);
        // remove from the middle, then the last entry
        send_beat(OP_REMOVE, 2, 0);
        send_beat(OP_REMOVE, 3, 0);
        send_beat(OP_READ, 3, 0);
        send_beat(OP_READ, 0, 0);
        send_beat(OP_APPEND, 0, 32'ha5a5_a5a5);
      end

      if (phase == 1) begin
        // fill up, then hit the full array from every side
        while (stored_count < CAPACITY) begin
          send_beat(OP_APPEND, POS_W'($urandom_range(127)), $urandom);
        end
        send_beat(OP_APPEND, 0, $urandom);
        send_beat(OP_INSERT, 0, $urandom);
        send_beat(OP_INSERT, POS_W'(CAPACITY), $urandom);
        send_beat(OP_INSERT, POS_W'(CAPACITY + 1), $urandom);
        send_beat(OP_INSERT, 127, $urandom);
        send_beat(OP_READ, POS_W'(CAPACITY - 1), 0);
        send_beat(OP_READ, POS_W'(CAPACITY), 0);
        send_beat(OP_REMOVE, POS_W'(CAPACITY - 1), 0);
      end

      for (n = 0; n < RANDOM_BEATS; n++) send_random(((n / 20) % 2) == 0);

      if (phase == 2) begin
        // empty the array completely and poke at it once empty
        while (stored_count > 0) begin
          send_beat(OP_REMOVE, POS_W'($urandom_range(stored_count - 1)), $urandom);
        end
        send_beat(OP_READ, 0, 0);
        send_beat(OP_REMOVE, 0, 0);
      end
    end

    // let everything drain, then allow for stray beats
    in_valid <= 1'b0;
    @(posedge clk);
    stall_pct = 0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (failures == 0) begin
      $display("ordered_array_insert_remove_core_test: PASS");
    end else begin
      $display("ordered_array_insert_remove_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/oai_pkg.sv
design/oai_datapath.sv
design/oai_ctrl.sv
design/ordered_array_insert_remove_core.sv
sim/oai_array_checker.sv
sim/ordered_array_insert_remove_core_test.sv
